// ----- rtl/lpg_pkg.sv -----
package lpg_pkg;

  // Field widths of the item payloads.
  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 16;
  localparam int ADDR_BITS  = 32;

  // Configuration register widths.
  localparam int WIDTH_BITS     = 12;
  localparam int PAN_BITS       = 11;
  localparam int BPP_BITS       = 4;
  localparam int PITCH_BITS     = 15;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 3;

  // Error term holds values between minus and plus twice the major delta.
  localparam int ERR_BITS = COORD_BITS + 3;
  // Width of a non-negative coordinate plus its pan offset.
  localparam int SUM_BITS = ((COORD_BITS - 1 > PAN_BITS) ? COORD_BITS - 1 : PAN_BITS) + 1;
  // Width used to compare a non-negative coordinate with a screen size.
  localparam int CMP_BITS = (COORD_BITS - 1 > WIDTH_BITS) ? COORD_BITS - 1 : WIDTH_BITS;
  localparam int AX_BITS  = SUM_BITS + BPP_BITS;
  localparam int AY_BITS  = SUM_BITS + PITCH_BITS;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_X           = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_Y           = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_PITCH       = 3'd5;

  // Register values after reset.
  localparam logic [WIDTH_BITS-1:0] RST_SCREEN_WIDTH    = 12'd640;
  localparam logic [WIDTH_BITS-1:0] RST_SCREEN_HEIGHT   = 12'd480;
  localparam logic [PAN_BITS-1:0]   RST_PAN_X           = 11'd0;
  localparam logic [PAN_BITS-1:0]   RST_PAN_Y           = 11'd0;
  localparam logic [BPP_BITS-1:0]   RST_BYTES_PER_PIXEL = 4'd2;
  localparam logic [PITCH_BITS-1:0] RST_ROW_PITCH       = 15'd1280;

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic [ADDR_BITS-1:0]         buffer_base;
  } lpg_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]         write_address;
    logic [COLOR_BITS-1:0]        write_color;
    logic                         visible;
    logic                         last_pixel;
  } lpg_out_t;

endpackage

// ----- rtl/line_pixel_generator_top.sv -----
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  lpg_pkg::lpg_in_t (load or tick item)
// out_      output     out_valid/out_stall  lpg_pkg::lpg_out_t (one pixel item)
// cfg_      input      cfg_we               cfg_index selects, cfg_data is written
//
// One item is accepted per cycle while the output is free or being taken.
// A tick taken at a clock edge places its pixel, address included, in the
// output register at that edge, so the pixel is offered from the next cycle.
// Loads produce no pixel, nor do ticks that find no line in progress.
// Reset is synchronous and active low; it clears the walker and the output
// valid and returns the configuration registers to their defaults.
// While a pixel waits with out_stall high, in_stall is high and no item is taken.
module line_pixel_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lpg_pkg::lpg_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lpg_pkg::lpg_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [lpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lpg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB = lpg_pkg::COORD_BITS;
  localparam int EB = lpg_pkg::ERR_BITS;

  // Configuration registers.
  logic [lpg_pkg::WIDTH_BITS-1:0] scr_w_r;
  logic [lpg_pkg::WIDTH_BITS-1:0] scr_h_r;
  logic [lpg_pkg::PAN_BITS-1:0]   pan_x_r;
  logic [lpg_pkg::PAN_BITS-1:0]   pan_y_r;
  logic [lpg_pkg::BPP_BITS-1:0]   bpp_r;
  logic [lpg_pkg::PITCH_BITS-1:0] pitch_r;

  // A write with an index beyond the register list is simply dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= lpg_pkg::RST_SCREEN_WIDTH;
      scr_h_r <= lpg_pkg::RST_SCREEN_HEIGHT;
      pan_x_r <= lpg_pkg::RST_PAN_X;
      pan_y_r <= lpg_pkg::RST_PAN_Y;
      bpp_r   <= lpg_pkg::RST_BYTES_PER_PIXEL;
      pitch_r <= lpg_pkg::RST_ROW_PITCH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpg_pkg::REG_SCREEN_WIDTH:    scr_w_r <= cfg_data[lpg_pkg::WIDTH_BITS-1:0];
        lpg_pkg::REG_SCREEN_HEIGHT:   scr_h_r <= cfg_data[lpg_pkg::WIDTH_BITS-1:0];
        lpg_pkg::REG_PAN_X:           pan_x_r <= cfg_data[lpg_pkg::PAN_BITS-1:0];
        lpg_pkg::REG_PAN_Y:           pan_y_r <= cfg_data[lpg_pkg::PAN_BITS-1:0];
        lpg_pkg::REG_BYTES_PER_PIXEL: bpp_r   <= cfg_data[lpg_pkg::BPP_BITS-1:0];
        lpg_pkg::REG_ROW_PITCH:       pitch_r <= cfg_data[lpg_pkg::PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register may load when it is empty or its pixel is
  // taken in the same cycle, and every input item waits for that.
  logic out_valid_r;
  logic out_ready;
  logic in_acc;
  logic load_acc;
  logic tick_acc;

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = !out_ready;
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_data.mode == lpg_pkg::MODE_LOAD);

  // Walker state.
  logic                 busy_r;
  logic signed [CB-1:0] cur_x_r;
  logic signed [CB-1:0] cur_y_r;
  logic signed [EB-1:0] err_r;
  logic [CB-1:0]        maj_r;
  logic [CB-1:0]        min_r;
  logic signed [1:0]    step_x_r;
  logic signed [1:0]    step_y_r;
  logic                 steep_r;
  logic [CB-1:0]        steps_left_r;
  logic [lpg_pkg::COLOR_BITS-1:0] color_r;
  logic [lpg_pkg::ADDR_BITS-1:0]  base_r;

  // A tick while no line is in progress is accepted and produces nothing.
  assign tick_acc = in_acc && (in_data.mode == lpg_pkg::MODE_TICK) && busy_r;

  // Line set-up from the end points of a load item.
  logic signed [CB:0]   dx;
  logic signed [CB:0]   dy;
  logic [CB-1:0]        adx;
  logic [CB-1:0]        ady;
  logic                 ld_steep;
  logic [CB-1:0]        ld_maj;
  logic [CB-1:0]        ld_min;
  logic signed [EB-1:0] ld_err;
  logic signed [1:0]    ld_step_x;
  logic signed [1:0]    ld_step_y;

  always_comb begin
    dx = {in_data.x_end[CB-1], in_data.x_end} - {in_data.x_start[CB-1], in_data.x_start};
    dy = {in_data.y_end[CB-1], in_data.y_end} - {in_data.y_start[CB-1], in_data.y_start};
    adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    ld_step_x = dx[CB] ? 2'sb11 : ((dx == '0) ? 2'sb00 : 2'sb01);
    ld_step_y = dy[CB] ? 2'sb11 : ((dy == '0) ? 2'sb00 : 2'sb01);
    ld_steep = ady > adx;
    ld_maj = ld_steep ? ady : adx;
    ld_min = ld_steep ? adx : ady;
    ld_err = EB'({ld_min, 1'b0}) - EB'(ld_maj);
  end

  // One Bresenham step from the present state.
  logic                 err_ge0;
  logic                 last;
  logic                 move_x;
  logic                 move_y;
  logic signed [CB-1:0] step_x_ext;
  logic signed [CB-1:0] step_y_ext;
  logic signed [EB-1:0] err_nxt;
  logic signed [CB-1:0] cur_x_nxt;
  logic signed [CB-1:0] cur_y_nxt;

  always_comb begin
    err_ge0 = !err_r[EB-1];
    last = steps_left_r == '0;
    // The major axis moves every step, the minor one when the error allows.
    move_x = !steep_r || err_ge0;
    move_y = steep_r || err_ge0;
    step_x_ext = {{(CB-2){step_x_r[1]}}, step_x_r};
    step_y_ext = {{(CB-2){step_y_r[1]}}, step_y_r};
    err_nxt = err_r - (err_ge0 ? EB'({maj_r, 1'b0}) : EB'(0)) + EB'({min_r, 1'b0});
    cur_x_nxt = cur_x_r + (move_x ? step_x_ext : CB'(0));
    cur_y_nxt = cur_y_r + (move_y ? step_y_ext : CB'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load_acc) begin
      busy_r <= 1'b1;
    end else if (tick_acc && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      cur_x_r      <= in_data.x_start;
      cur_y_r      <= in_data.y_start;
      err_r        <= ld_err;
      maj_r        <= ld_maj;
      min_r        <= ld_min;
      step_x_r     <= ld_step_x;
      step_y_r     <= ld_step_y;
      steep_r      <= ld_steep;
      steps_left_r <= ld_maj;
      color_r      <= in_data.pixel_color;
      base_r       <= in_data.buffer_base;
    end else if (tick_acc && !last) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      err_r        <= err_nxt;
      steps_left_r <= steps_left_r - CB'(1);
    end
  end

  // Clipping test and byte address of the pixel being emitted. Only a pixel
  // with non-negative coordinates reaches the address, so the sign bit is
  // dropped before the pan offset is added.
  logic                          vis;
  logic [lpg_pkg::SUM_BITS-1:0]  xsum;
  logic [lpg_pkg::SUM_BITS-1:0]  ysum;
  logic [lpg_pkg::AX_BITS-1:0]   ax;
  logic [lpg_pkg::AY_BITS-1:0]   ay;
  logic [lpg_pkg::ADDR_BITS-1:0] addr;

  always_comb begin
    vis = !cur_x_r[CB-1] && !cur_y_r[CB-1] &&
          (lpg_pkg::CMP_BITS'(cur_x_r[CB-2:0]) < lpg_pkg::CMP_BITS'(scr_w_r)) &&
          (lpg_pkg::CMP_BITS'(cur_y_r[CB-2:0]) < lpg_pkg::CMP_BITS'(scr_h_r));
    xsum = lpg_pkg::SUM_BITS'(cur_x_r[CB-2:0]) + lpg_pkg::SUM_BITS'(pan_x_r);
    ysum = lpg_pkg::SUM_BITS'(cur_y_r[CB-2:0]) + lpg_pkg::SUM_BITS'(pan_y_r);
    ax = lpg_pkg::AX_BITS'(xsum) * lpg_pkg::AX_BITS'(bpp_r);
    ay = lpg_pkg::AY_BITS'(ysum) * lpg_pkg::AY_BITS'(pitch_r);
    // A clipped pixel carries address zero; the sum wraps at the address width.
    addr = vis ? (base_r + lpg_pkg::ADDR_BITS'(ax) + lpg_pkg::ADDR_BITS'(ay)) :
                 lpg_pkg::ADDR_BITS'(0);
  end

  // Output register: the pixel of the tick just taken.
  lpg_pkg::lpg_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= tick_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_data_r.pixel_x       <= cur_x_r;
      out_data_r.pixel_y       <= cur_y_r;
      out_data_r.write_address <= addr;
      out_data_r.write_color   <= color_r;
      out_data_r.visible       <= vis;
      out_data_r.last_pixel    <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A load leaves the walker busy with its step count equal to the major delta.
  a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> busy_r && (steps_left_r == maj_r))
    else $error("walker not armed after a load");

  // Emitting the end point finishes the line.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_acc && last) |=> !busy_r)
    else $error("walker still busy after the end point");

  // A clipped pixel never carries an address.
  a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.visible) |-> (out_data.write_address == '0))
    else $error("clipped pixel with a non-zero address");

  // The input is held back only while a pixel waits at the output.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled with a free output");

endmodule
